@@ rtl/core/assert_macros.svh @@
// Shared assertion macros, clocked on i_clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ROIC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ROIC_ASSERT_NEVER(lbl, cond, msg) \
    `ROIC_ASSERT(lbl, !(cond), msg)

`endif

@@ rtl/core/roic_pkg.sv @@
package roic_pkg;

    localparam int VALUE_W   = 32;
    localparam int POS_W     = 12;
    localparam int DIM_W     = 13;
    localparam int ROI_W     = 16;
    localparam int COORD_W   = 18;
    localparam int CFG_IDX_W = 2;

    localparam int PIXEL_BITS_DEF = 32;
    localparam int MAX_DIM_DEF    = 4096;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CROP_MODE   = 2'd0,
        CFG_PERMISSIVE  = 2'd1,
        CFG_KEEP_UNSEEN = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic crop_mode;
        logic permissive_clamp;
        logic keep_unseen_frames;
    } t_cfg;

    typedef struct packed {
        logic [VALUE_W-1:0]   pixel_value;
        logic [POS_W-1:0]     pixel_row;
        logic [POS_W-1:0]     pixel_col;
        logic [DIM_W-1:0]     frame_rows;
        logic [DIM_W-1:0]     frame_cols;
        logic [ROI_W-1:0]     roi_min_x;
        logic [ROI_W-1:0]     roi_min_y;
        logic [ROI_W-1:0]     roi_max_x;
        logic [ROI_W-1:0]     roi_max_y;
        logic                 frame_end;
    } t_pix;

    typedef struct packed {
        logic emit;
        logic last;
        logic err;
    } t_res;

endpackage

@@ rtl/core/roic_inreg.sv @@
module roic_inreg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  roic_pkg::t_pix i_pix,
    input  logic           i_adv,
    output logic           o_valid,
    output roic_pkg::t_pix o_pix
);

    logic           r_valid;
    logic           n_valid;
    roic_pkg::t_pix r_pix;
    logic           w_take;

    assign o_in_ready = !r_valid || i_adv;
    assign w_take     = i_in_valid && o_in_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_adv) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pix <= i_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule

@@ rtl/core/roic_decide.sv @@
module roic_decide #(
    parameter int PIXEL_BITS = roic_pkg::PIXEL_BITS_DEF,
    parameter int MAX_DIM    = roic_pkg::MAX_DIM_DEF,
    localparam int ValW      = (PIXEL_BITS < roic_pkg::VALUE_W) ? PIXEL_BITS : roic_pkg::VALUE_W
) (
    input  roic_pkg::t_cfg  i_cfg,
    input  roic_pkg::t_pix  i_pix,
    output roic_pkg::t_res  o_res,
    output logic [ValW-1:0] o_value
);

    localparam int DimMax = (1 << roic_pkg::DIM_W) - 1;
    localparam int DimCap = (MAX_DIM > DimMax) ? DimMax : MAX_DIM;
    localparam logic [roic_pkg::DIM_W-1:0] CAP = roic_pkg::DIM_W'(DimCap);

    logic [roic_pkg::DIM_W-1:0] w_rows_u;
    logic [roic_pkg::DIM_W-1:0] w_cols_u;
    roic_pkg::t_coord w_rows, w_cols, w_row, w_col;
    roic_pkg::t_coord w_minx, w_miny, w_maxx, w_maxy;
    roic_pkg::t_coord w_cminx, w_cminy, w_cmaxx, w_cmaxy;
    logic w_unseen, w_neg, w_outside, w_inside, w_crop_last;

    always_comb begin
        w_rows_u = (i_pix.frame_rows > CAP) ? CAP : i_pix.frame_rows;
        w_cols_u = (i_pix.frame_cols > CAP) ? CAP : i_pix.frame_cols;
        w_rows   = $signed(roic_pkg::COORD_W'(w_rows_u));
        w_cols   = $signed(roic_pkg::COORD_W'(w_cols_u));
        w_row    = $signed(roic_pkg::COORD_W'(i_pix.pixel_row));
        w_col    = $signed(roic_pkg::COORD_W'(i_pix.pixel_col));
        w_minx   = roic_pkg::COORD_W'($signed(i_pix.roi_min_x));
        w_miny   = roic_pkg::COORD_W'($signed(i_pix.roi_min_y));
        w_maxx   = roic_pkg::COORD_W'($signed(i_pix.roi_max_x));
        w_maxy   = roic_pkg::COORD_W'($signed(i_pix.roi_max_y));

        w_unseen = (w_maxx < 0) || (w_minx >= w_cols) || (w_maxy < 0) || (w_miny >= w_rows);

        w_cminx = w_minx;
        w_cminy = w_miny;
        w_cmaxx = w_maxx;
        w_cmaxy = w_maxy;
        if (i_cfg.permissive_clamp) begin
            if (w_minx < 0) w_cminx = '0;
            if (w_miny < 0) w_cminy = '0;
            if (w_maxx > w_cols) w_cmaxx = w_cols;
            if (w_maxy > w_rows) w_cmaxy = w_rows;
        end

        w_neg       = (w_cmaxx < w_cminx) || (w_cmaxy < w_cminy);
        w_outside   = !((w_cminx >= 0) && (w_cminy >= 0)
                        && (w_cmaxx <= w_cols) && (w_cmaxy <= w_rows));
        w_inside    = (w_row >= w_cminy) && (w_row < w_cmaxy)
                      && (w_col >= w_cminx) && (w_col < w_cmaxx);
        w_crop_last = (w_row == w_cmaxy - 1) && (w_col == w_cmaxx - 1);

        o_res   = '0;
        o_value = '0;
        priority if (w_unseen) begin
            o_res.emit = i_cfg.keep_unseen_frames;
            o_res.last = i_pix.frame_end;
        end else if (w_neg) begin
            o_res.emit = i_pix.frame_end;
            o_res.last = 1'b1;
            o_res.err  = 1'b1;
        end else if (w_outside) begin
            o_res.emit = 1'b0;
        end else if (i_cfg.crop_mode) begin
            o_res.emit = w_inside;
            o_res.last = w_crop_last;
            o_value    = i_pix.pixel_value[ValW-1:0];
        end else begin
            o_res.emit = 1'b1;
            o_res.last = i_pix.frame_end;
            o_value    = w_inside ? i_pix.pixel_value[ValW-1:0] : '0;
        end
    end

endmodule

@@ rtl/core/roic_outreg.sv @@
`include "assert_macros.svh"

module roic_outreg #(
    parameter int VAL_W = roic_pkg::VALUE_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s1_valid,
    input  roic_pkg::t_res               i_res,
    input  logic [VAL_W-1:0]             i_value,
    output logic                         o_adv,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [roic_pkg::VALUE_W-1:0] o_out_value,
    output logic                         o_out_last,
    output logic                         o_roi_error
);

    logic             r_out_valid;
    logic             n_out_valid;
    logic [VAL_W-1:0] r_value;
    logic             r_last;
    logic             r_err;
    logic             w_free;
    logic             w_load;

    assign w_free = !r_out_valid || i_out_ready;
    assign o_adv  = i_s1_valid && w_free;
    assign w_load = o_adv && i_res.emit;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_free) begin
            n_out_valid = w_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_value <= i_value;
            r_last  <= i_res.last;
            r_err   <= i_res.err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = roic_pkg::VALUE_W'(r_value);
    assign o_out_last  = r_last;
    assign o_roi_error = r_err;

    `ROIC_ASSERT(a_err_shape, (r_out_valid && r_err) |-> (r_last && (r_value == '0)), "error result not last or not zero")
    `ROIC_ASSERT(a_emit_loads, (o_adv && i_res.emit) |=> r_out_valid, "emitted result lost")
    `ROIC_ASSERT(a_drop_empty, (o_adv && !i_res.emit) |=> !r_out_valid, "dropped item produced a result")
    `ROIC_ASSERT_NEVER(a_no_overrun, w_load && r_out_valid && !i_out_ready, "result overwritten while stalled")

endmodule

@@ rtl/core/roi_crop_or_mask_pixels_unit.sv @@
// Input transfer to output transfer passes the input register, then the result register.
// One pixel per cycle unless output stalls; ready passes back combinationally through both registers.
// Pixels that produce no result leave no bubble at the output; they wait only behind a held result.
// Reset: synchronous, active low; clears pipeline valid flags and all three control registers.
module roi_crop_or_mask_pixels_unit #(
    parameter int PIXEL_BITS = roic_pkg::PIXEL_BITS_DEF,
    parameter int MAX_DIM    = roic_pkg::MAX_DIM_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [roic_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic                             i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [roic_pkg::VALUE_W-1:0]     i_pixel_value,
    input  logic [roic_pkg::POS_W-1:0]       i_pixel_row,
    input  logic [roic_pkg::POS_W-1:0]       i_pixel_col,
    input  logic [roic_pkg::DIM_W-1:0]       i_frame_rows,
    input  logic [roic_pkg::DIM_W-1:0]       i_frame_cols,
    input  logic signed [roic_pkg::ROI_W-1:0] i_roi_min_x,
    input  logic signed [roic_pkg::ROI_W-1:0] i_roi_min_y,
    input  logic signed [roic_pkg::ROI_W-1:0] i_roi_max_x,
    input  logic signed [roic_pkg::ROI_W-1:0] i_roi_max_y,
    input  logic                             i_frame_end,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [roic_pkg::VALUE_W-1:0]     o_out_value,
    output logic                             o_out_last,
    output logic                             o_roi_error
);

    localparam int ValW = (PIXEL_BITS < roic_pkg::VALUE_W) ? PIXEL_BITS : roic_pkg::VALUE_W;

    roic_pkg::t_cfg  r_cfg;
    roic_pkg::t_cfg  n_cfg;
    roic_pkg::t_pix  w_in_pix;
    roic_pkg::t_pix  w_s1_pix;
    roic_pkg::t_res  w_res;
    logic            w_s1_valid;
    logic            w_adv;
    logic [ValW-1:0] w_value;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                roic_pkg::CFG_CROP_MODE:   n_cfg.crop_mode          = i_cfg_data;
                roic_pkg::CFG_PERMISSIVE:  n_cfg.permissive_clamp   = i_cfg_data;
                roic_pkg::CFG_KEEP_UNSEEN: n_cfg.keep_unseen_frames = i_cfg_data;
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        w_in_pix.pixel_value = i_pixel_value;
        w_in_pix.pixel_row   = i_pixel_row;
        w_in_pix.pixel_col   = i_pixel_col;
        w_in_pix.frame_rows  = i_frame_rows;
        w_in_pix.frame_cols  = i_frame_cols;
        w_in_pix.roi_min_x   = i_roi_min_x;
        w_in_pix.roi_min_y   = i_roi_min_y;
        w_in_pix.roi_max_x   = i_roi_max_x;
        w_in_pix.roi_max_y   = i_roi_max_y;
        w_in_pix.frame_end   = i_frame_end;
    end

    roic_inreg u_inreg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_pix      (w_in_pix),
        .i_adv      (w_adv),
        .o_valid    (w_s1_valid),
        .o_pix      (w_s1_pix)
    );

    roic_decide #(
        .PIXEL_BITS (PIXEL_BITS),
        .MAX_DIM    (MAX_DIM)
    ) u_decide (
        .i_cfg   (r_cfg),
        .i_pix   (w_s1_pix),
        .o_res   (w_res),
        .o_value (w_value)
    );

    roic_outreg #(
        .VAL_W (ValW)
    ) u_outreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (w_s1_valid),
        .i_res       (w_res),
        .i_value     (w_value),
        .o_adv       (w_adv),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_value (o_out_value),
        .o_out_last  (o_out_last),
        .o_roi_error (o_roi_error)
    );

endmodule
